FILE: rtl/core/ptog_pkg.sv
// Shared constants, register indexes, stage types and projection helpers for the grid projector.
package ptog_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;

    localparam int NUM_REGS   = 8;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int S_DATA_W = 136;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 1;

    typedef enum logic [2:0] {
        REG_COL_GAIN_X = 3'd0,
        REG_COL_GAIN_Y = 3'd1,
        REG_COL_GAIN_Z = 3'd2,
        REG_COL_OFFSET = 3'd3,
        REG_ROW_GAIN_X = 3'd4,
        REG_ROW_GAIN_Y = 3'd5,
        REG_ROW_GAIN_Z = 3'd6,
        REG_ROW_OFFSET = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        CMD_MARK = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
        32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0
    };

    typedef struct packed {
        cmd_t        cmd;
        logic        colored;
        logic [7:0]  read_col;
        logic [7:0]  read_row;
        logic [63:0] col_px;
        logic [63:0] col_py;
        logic [63:0] col_pz;
        logic [63:0] row_px;
        logic [63:0] row_py;
        logic [63:0] row_pz;
    } st1_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        colored;
        logic [7:0]  read_col;
        logic [7:0]  read_row;
        logic [63:0] col_a;
        logic [63:0] col_b;
        logic [63:0] row_a;
        logic [63:0] row_b;
    } st2_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        colored;
        logic [7:0]  read_col;
        logic [7:0]  read_row;
        logic [63:0] col_sum;
        logic [63:0] row_sum;
    } st3_t;

    // A Q31.32 sum truncated toward zero lands in [0, lim) when it is non-negative with a
    // small integer part, or when it lies strictly between minus one and zero.
    function automatic logic axis_in_range(logic [63:0] s, logic [31:0] lim);
        logic frac_neg;
        frac_neg = (s[63:32] == 32'hFFFF_FFFF) && (s[31:0] != 32'd0);
        axis_in_range = s[63] ? frac_neg : ({1'b0, s[62:32]} < lim);
    endfunction

    function automatic logic [31:0] axis_coord(logic [63:0] s);
        axis_coord = s[63] ? 32'd0 : {1'b0, s[62:32]};
    endfunction

endpackage

FILE: rtl/core/point_to_occupancy_grid_top.sv
// Top level of the point to occupancy grid projector: config registers, pipeline and grid store.
//
// Each input beat either projects one Q15.16 point through two affine rows and marks the
// resulting grid cell, or reads one cell back; every beat yields exactly one result beat.
// The block takes one beat per clock cycle while the output is not stalled and no sweep
// runs, and returns its result through one stage of six parallel 32x32 multipliers, two
// stages of 64-bit adds, one stage of truncation and bounds checks, and one stage of grid
// store access, which has a single read and a single write port and serves one beat per
// cycle when not stalled. After reset the store, 2^(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT))
// cells (65536 at the default 256x256 grid), is swept clear one cell per cycle while
// s_tready stays low; configuration writes are taken during the sweep. Registers must only
// be written while no beat is in flight.
module point_to_occupancy_grid_top #(
    parameter int GRID_WIDTH  = ptog_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ptog_pkg::GRID_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], red[103:96], green[111:104],
    // blue[119:112], read_col[127:120], read_row[135:128]
    input  logic [ptog_pkg::S_DATA_W-1:0]   s_tdata,
    // command[0]
    input  logic [ptog_pkg::S_USER_W-1:0]   s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_col[7:0], cell_row[15:8], cell_value[16], zero[23:17]
    output logic [ptog_pkg::M_DATA_W-1:0]   m_tdata,
    // in_bounds[0]
    output logic [ptog_pkg::M_USER_W-1:0]   m_tuser,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptog_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ptog_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ptog_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int COL_W     = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int ROW_W     = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic [31:0] WIDTH_LIM  = 32'(GRID_WIDTH);
    localparam logic [31:0] HEIGHT_LIM = 32'(GRID_HEIGHT);

    logic [ptog_pkg::CFG_DATA_W-1:0] cfg_reg [ptog_pkg::NUM_REGS];
    ptog_pkg::cfg_idx_t              cfg_idx;

    logic [4:0]     valid_reg;
    logic [4:0]     stage_rdy;
    ptog_pkg::st1_t st1_reg, st1_next;
    ptog_pkg::st2_t st2_reg, st2_next;
    ptog_pkg::st3_t st3_reg, st3_next;

    ptog_pkg::cmd_t    cmd4_reg;
    logic              inb4_reg, inb4_next;
    logic              colored4_reg;
    logic [7:0]        col4_reg, col4_next;
    logic [7:0]        row4_reg, row4_next;
    logic [ADDR_W-1:0] addr4_reg, addr4_next;

    ptog_pkg::cmd_t cmd5_reg;
    logic           inb5_reg;
    logic           val5_reg;
    logic [7:0]     col5_reg;
    logic [7:0]     row5_reg;
    logic           rd_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              grid_mem [MEM_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic              out_val;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = ptog_pkg::cfg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ptog_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= ptog_pkg::CFG_RESET[i];
            end
        end else if (psel && penable && pwrite && pready) begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    assign prdata = cfg_reg[cfg_idx];

    // Stall chain: a stage loads when it is empty or its content moves on.
    always_comb begin
        stage_rdy[4] = !valid_reg[4] || m_tready;
        for (int k = 3; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    assign s_tready = stage_rdy[0] && !clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_rdy[0]) begin
                valid_reg[0] <= s_tvalid && s_tready;
            end
            for (int k = 1; k < 5; k++) begin
                if (stage_rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: products.
    always_comb begin
        logic signed [31:0] px, py, pz;
        logic signed [63:0] cx, cy, cz, rx, ry, rz;
        px = s_tdata[31:0];
        py = s_tdata[63:32];
        pz = s_tdata[95:64];
        cx = px * $signed(cfg_reg[ptog_pkg::REG_COL_GAIN_X]);
        cy = py * $signed(cfg_reg[ptog_pkg::REG_COL_GAIN_Y]);
        cz = pz * $signed(cfg_reg[ptog_pkg::REG_COL_GAIN_Z]);
        rx = px * $signed(cfg_reg[ptog_pkg::REG_ROW_GAIN_X]);
        ry = py * $signed(cfg_reg[ptog_pkg::REG_ROW_GAIN_Y]);
        rz = pz * $signed(cfg_reg[ptog_pkg::REG_ROW_GAIN_Z]);
        st1_next.cmd      = ptog_pkg::cmd_t'(s_tuser[0]);
        st1_next.colored  = (s_tdata[119:96] != 24'd0);
        st1_next.read_col = s_tdata[127:120];
        st1_next.read_row = s_tdata[135:128];
        st1_next.col_px   = cx;
        st1_next.col_py   = cy;
        st1_next.col_pz   = cz;
        st1_next.row_px   = rx;
        st1_next.row_py   = ry;
        st1_next.row_pz   = rz;
    end

    // Stage 2: pairwise sums, with the offset placed at Q31.32.
    always_comb begin
        logic [31:0] co, ro;
        co = cfg_reg[ptog_pkg::REG_COL_OFFSET];
        ro = cfg_reg[ptog_pkg::REG_ROW_OFFSET];
        st2_next.cmd      = st1_reg.cmd;
        st2_next.colored  = st1_reg.colored;
        st2_next.read_col = st1_reg.read_col;
        st2_next.read_row = st1_reg.read_row;
        st2_next.col_a    = st1_reg.col_px + st1_reg.col_py;
        st2_next.col_b    = st1_reg.col_pz + {{16{co[31]}}, co, 16'd0};
        st2_next.row_a    = st1_reg.row_px + st1_reg.row_py;
        st2_next.row_b    = st1_reg.row_pz + {{16{ro[31]}}, ro, 16'd0};
    end

    // Stage 3: row sums.
    always_comb begin
        st3_next.cmd      = st2_reg.cmd;
        st3_next.colored  = st2_reg.colored;
        st3_next.read_col = st2_reg.read_col;
        st3_next.read_row = st2_reg.read_row;
        st3_next.col_sum  = st2_reg.col_a + st2_reg.col_b;
        st3_next.row_sum  = st2_reg.row_a + st2_reg.row_b;
    end

    // Stage 4: truncation, bounds and store address.
    always_comb begin
        logic [31:0] cc, rc;
        logic        cok, rok;
        if (st3_reg.cmd == ptog_pkg::CMD_READ) begin
            cc  = {24'd0, st3_reg.read_col};
            rc  = {24'd0, st3_reg.read_row};
            cok = cc < WIDTH_LIM;
            rok = rc < HEIGHT_LIM;
        end else begin
            cc  = ptog_pkg::axis_coord(st3_reg.col_sum);
            rc  = ptog_pkg::axis_coord(st3_reg.row_sum);
            cok = ptog_pkg::axis_in_range(st3_reg.col_sum, WIDTH_LIM);
            rok = ptog_pkg::axis_in_range(st3_reg.row_sum, HEIGHT_LIM);
        end
        inb4_next  = cok && rok;
        col4_next  = inb4_next ? cc[7:0] : 8'd0;
        row4_next  = inb4_next ? rc[7:0] : 8'd0;
        addr4_next = {rc[ROW_W-1:0], cc[COL_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[0]) begin
            st1_reg <= st1_next;
        end
        if (stage_rdy[1]) begin
            st2_reg <= st2_next;
        end
        if (stage_rdy[2]) begin
            st3_reg <= st3_next;
        end
        if (stage_rdy[3]) begin
            cmd4_reg     <= st3_reg.cmd;
            colored4_reg <= st3_reg.colored;
            inb4_reg     <= inb4_next;
            col4_reg     <= col4_next;
            row4_reg     <= row4_next;
            addr4_reg    <= addr4_next;
        end
        if (stage_rdy[4]) begin
            cmd5_reg <= cmd4_reg;
            inb5_reg <= inb4_reg;
            val5_reg <= inb4_reg && colored4_reg;
            col5_reg <= col4_reg;
            row5_reg <= row4_reg;
        end
    end

    // Stage 5: grid store access and clearing sweep.
    always_comb begin
        clr_busy_next = clr_busy_reg && (clr_cnt_reg != '1);
        clr_cnt_next  = clr_busy_reg ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb begin
        mem_we    = clr_busy_reg || (stage_rdy[4] && valid_reg[3] && inb4_reg
                                     && (cmd4_reg == ptog_pkg::CMD_MARK));
        mem_waddr = clr_busy_reg ? clr_cnt_reg : addr4_reg;
        mem_wdata = clr_busy_reg ? 1'b0 : colored4_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[4]) begin
            rd_reg <= grid_mem[addr4_reg];
        end
    end

    assign out_val  = (cmd5_reg == ptog_pkg::CMD_READ) ? (inb5_reg && rd_reg) : val5_reg;
    assign m_tvalid = valid_reg[4];
    assign m_tdata  = {7'd0, out_val, row5_reg, col5_reg};
    assign m_tuser  = inb5_reg;

endmodule

FILE: rtl/core/ptog_checker.sv
// Port-level checker for the grid projector and its bind to the top level.
module ptog_checker #(
    parameter int GRID_WIDTH  = ptog_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ptog_pkg::GRID_HEIGHT_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptog_pkg::M_DATA_W-1:0] m_tdata,
    input logic [ptog_pkg::M_USER_W-1:0] m_tuser
);

    localparam logic [31:0] WIDTH_LIM  = 32'(GRID_WIDTH);
    localparam logic [31:0] HEIGHT_LIM = 32'(GRID_HEIGHT);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The grid is swept clear after reset before any point is taken.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("input taken during the clearing sweep");

    // An out-of-bounds result carries no cell and no mark.
    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("out-of-bounds result has nonzero fields");

    // An in-bounds cell fits the grid and the padding stays zero.
    a_inb_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[23:17] == 7'd0
            && ({24'd0, m_tdata[7:0]} < WIDTH_LIM || GRID_WIDTH > 256)
            && ({24'd0, m_tdata[15:8]} < HEIGHT_LIM || GRID_HEIGHT > 256))
        else $error("in-bounds result outside the grid");

endmodule

bind point_to_occupancy_grid_top ptog_checker #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
) u_ptog_checker (.*);

FILE: bench/tb.sv
// Self-checking bench for the point to occupancy grid projector, driven over stream and APB ports.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [31:0] reg_set_t [ptog_pkg::NUM_REGS];

    typedef struct packed {
        logic       in_bounds;
        logic [7:0] col;
        logic [7:0] row;
        logic       value;
    } cell_res_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // point_x[31:0], point_y[63:32], point_z[95:64], red[103:96], green[111:104],
    // blue[119:112], read_col[127:120], read_row[135:128]
    logic [ptog_pkg::S_DATA_W-1:0]   s_tdata = '0;
    // command[0]
    logic [ptog_pkg::S_USER_W-1:0]   s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // cell_col[7:0], cell_row[15:8], cell_value[16], zero[23:17]
    logic [ptog_pkg::M_DATA_W-1:0]   m_tdata;
    // in_bounds[0]
    logic [ptog_pkg::M_USER_W-1:0]   m_tuser;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ptog_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [ptog_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [ptog_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    logic [31:0]  proj_regs [ptog_pkg::NUM_REGS];
    bit           mark_map [0:ptog_pkg::GRID_WIDTH_DEF*ptog_pkg::GRID_HEIGHT_DEF-1];
    logic [15:0]  recent_cells [$];
    cell_res_t    pending_cells [$];
    int unsigned  src_idle = 0;
    int unsigned  dst_stall = 0;
    int unsigned  mismatch_count = 0;

    point_to_occupancy_grid_top dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < ptog_pkg::NUM_REGS; i++) proj_regs[i] = ptog_pkg::CFG_RESET[i];
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= dst_stall);

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // Integer cell coordinate of one affine row, truncated toward zero; bit 8 flags in range.
    function automatic logic [8:0] axis_cell(int base, logic signed [31:0] px,
                                             logic signed [31:0] py, logic signed [31:0] pz,
                                             int lim);
        longint acc;
        logic [63:0] mag;
        acc = longint'($signed(proj_regs[base])) * longint'(px)
            + longint'($signed(proj_regs[base+1])) * longint'(py)
            + longint'($signed(proj_regs[base+2])) * longint'(pz)
            + (longint'($signed(proj_regs[base+3])) <<< 16);
        if (acc < 0) begin
            mag = -acc;
            return {mag[63:32] == 32'd0, 8'd0};
        end
        return {acc[63:32] < lim, acc[39:32]};
    endfunction

    function automatic cell_res_t predict_cell(ptog_pkg::cmd_t cmd,
                                               logic [ptog_pkg::S_DATA_W-1:0] d);
        cell_res_t res;
        logic [8:0] c, r;
        res = '0;
        if (cmd == ptog_pkg::CMD_MARK) begin
            c = axis_cell(ptog_pkg::REG_COL_GAIN_X, d[31:0], d[63:32], d[95:64],
                          ptog_pkg::GRID_WIDTH_DEF);
            r = axis_cell(ptog_pkg::REG_ROW_GAIN_X, d[31:0], d[63:32], d[95:64],
                          ptog_pkg::GRID_HEIGHT_DEF);
            if (c[8] && r[8]) begin
                res = '{1'b1, c[7:0], r[7:0], |d[119:96]};
                mark_map[{r[7:0], c[7:0]}] = res.value;
                recent_cells.push_back({r[7:0], c[7:0]});
                if (recent_cells.size() > 64) void'(recent_cells.pop_front());
            end
        end else if (d[127:120] < ptog_pkg::GRID_WIDTH_DEF
                     && d[135:128] < ptog_pkg::GRID_HEIGHT_DEF) begin
            res = '{1'b1, d[127:120], d[135:128], mark_map[{d[135:128], d[127:120]}]};
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        cell_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata, 32'd0);
            end else begin
                want = pending_cells.pop_front();
                if (m_tuser[0] !== want.in_bounds)
                    report_mismatch("in_bounds", m_tuser[0], want.in_bounds);
                if (m_tdata[7:0] !== want.col)
                    report_mismatch("cell_col", m_tdata[7:0], want.col);
                if (m_tdata[15:8] !== want.row)
                    report_mismatch("cell_row", m_tdata[15:8], want.row);
                if (m_tdata[16] !== want.value)
                    report_mismatch("cell_value", m_tdata[16], want.value);
                if (m_tdata[23:17] !== 7'd0)
                    report_mismatch("padding", m_tdata[23:17], 32'd0);
            end
        end
        if (aresetn && s_tvalid && s_tready)
            pending_cells.push_back(predict_cell(ptog_pkg::cmd_t'(s_tuser[0]), s_tdata));
    end

    task automatic cfg_write(ptog_pkg::cfg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        proj_regs[idx] = val;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== val) report_mismatch("register readback", prdata, val);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(reg_set_t setting);
        for (int i = 0; i < ptog_pkg::NUM_REGS; i++)
            cfg_write(ptog_pkg::cfg_idx_t'(i), setting[i]);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
    endtask

    task automatic send_beat(ptog_pkg::cmd_t cmd, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [23:0] rgb, logic [7:0] rc,
                             logic [7:0] rr);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rr, rc, rgb, z, y, x};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic reg_set_t random_setting();
        reg_set_t s;
        for (int i = 0; i < ptog_pkg::NUM_REGS; i++) begin
            if ($urandom_range(19) == 0) s[i] = $urandom;
            else if (i % 4 == 3) s[i] = $urandom_range(192 << 16, 64 << 16);
            else s[i] = $urandom_range(1 << 17) - (1 << 16);
        end
        return s;
    endfunction

    task automatic test_register_access();
        for (int i = 0; i < ptog_pkg::NUM_REGS; i++) begin
            cfg_write(ptog_pkg::cfg_idx_t'(i), 32'h8000_0000);
            cfg_write(ptog_pkg::cfg_idx_t'(i), 32'h7FFF_FFFF);
        end
        apply_setting(ptog_pkg::CFG_RESET);
    endtask

    task automatic test_default_mapping();
        send_beat(ptog_pkg::CMD_MARK, 32'h0005_0000, 32'h0007_0000, 32'h0, 24'h000001,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd5, 8'd7);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd0, 8'd0);
        send_beat(ptog_pkg::CMD_MARK, 32'h0005_8000, 32'h0007_4000, 32'hFFFF_FFFF, 24'h0,
                  8'hFF, 8'hFF);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd5, 8'd7);
        send_beat(ptog_pkg::CMD_MARK, 32'hFFFF_8000, 32'hFFFF_4000, 32'h0, 24'h00FF00,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd0, 8'd0);
        send_beat(ptog_pkg::CMD_MARK, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 24'hFFFFFF,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_MARK, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0, 24'hFF0000,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd255, 8'd255);
        send_beat(ptog_pkg::CMD_MARK, 32'h0100_0000, 32'h0, 32'h0, 24'h000080, 8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_MARK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h1,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_MARK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h1,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd255, 8'd0);
        wait_drained();
    endtask

    task automatic test_sum_extremes();
        reg_set_t wrap_set;
        reg_set_t corner_set;
        wrap_set = '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        corner_set = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h00FF_0000};
        apply_setting(wrap_set);
        send_beat(ptog_pkg::CMD_MARK, 32'h8000_0000, 32'h8000_0000, 32'h0, 24'h1, 8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_MARK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h1,
                  8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_MARK, 32'h0, 32'h0, 32'h0, 24'h1, 8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_MARK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h1,
                  8'h0, 8'h0);
        wait_drained();
        apply_setting(corner_set);
        send_beat(ptog_pkg::CMD_MARK, $urandom, $urandom, $urandom, 24'h000100, 8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd0, 8'd255);
        send_beat(ptog_pkg::CMD_MARK, $urandom, $urandom, $urandom, 24'h0, 8'h0, 8'h0);
        send_beat(ptog_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 24'h0, 8'd0, 8'd255);
        wait_drained();
    endtask

    task automatic test_random_stream(int unsigned src_pct, int unsigned dst_pct, int count,
                                      reg_set_t setting);
        ptog_pkg::cmd_t cmd;
        logic [31:0]    pt [3];
        logic [23:0]    rgb;
        logic [15:0]    pick;
        wait_drained();
        apply_setting(setting);
        src_idle = src_pct;
        dst_stall = dst_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_drained();
            cmd = ($urandom_range(99) < 35) ? ptog_pkg::CMD_READ : ptog_pkg::CMD_MARK;
            for (int k = 0; k < 3; k++)
                pt[k] = ($urandom_range(99) < 15) ? $urandom
                                                  : $urandom_range(128 << 16) - (64 << 16);
            rgb = ($urandom_range(3) == 0) ? 24'h0 : 24'($urandom);
            pick = 16'($urandom);
            if (cmd == ptog_pkg::CMD_READ && recent_cells.size() != 0
                && $urandom_range(1) == 1)
                pick = recent_cells[$urandom_range(recent_cells.size() - 1)];
            send_beat(cmd, pt[0], pt[1], pt[2], rgb, pick[7:0], pick[15:8]);
        end
        wait_drained();
    endtask

    initial begin
        reg_set_t setting;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_register_access();
        test_default_mapping();
        test_sum_extremes();
        setting = random_setting();
        test_random_stream(0, 0, 370, setting);
        setting = random_setting();
        test_random_stream(76, 0, 370, setting);
        setting = random_setting();
        test_random_stream(0, 76, 370, setting);
        setting = random_setting();
        test_random_stream(26, 26, 370, setting);
        setting = '{default: 32'h7FFF_FFFF};
        test_random_stream(26, 26, 35, setting);
        setting = '{default: 32'h8000_0000};
        test_random_stream(26, 26, 35, setting);
        dst_stall = 0;
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
